// ===== rtl/keyed_strength_merge_table_defines.svh =====
// Assertion macros shared by the keyed strength merge table RTL.
// Included by kstm_dp, the module that carries the concurrent assertions; no other dependencies.
`ifndef KEYED_STRENGTH_MERGE_TABLE_DEFINES_SVH
`define KEYED_STRENGTH_MERGE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KSTM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("keyed strength merge table: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KSTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("keyed strength merge table: next-cycle check failed");

`endif

// ===== rtl/kstm_pkg.sv =====
// Package for the keyed strength merge table: sizes, command codes,
// controller states and the command/status structs between controller and datapath.
`timescale 1ns / 1ps

package kstm_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 48;
    localparam int STR_W   = 8;
    localparam int CMD_W   = 2;
    localparam int WORD_W  = KEY_W + STR_W;

    localparam logic [CMD_W-1:0] CMD_MERGE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_READ_DATA,
        ST_MISC,
        ST_RESULT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;          // capture the accepted transaction
        logic scan_en;       // advance the table scan by one entry
        logic commit_hit;    // write back the averaged strength of the matching entry
        logic commit_miss;   // append the key, or flag the drop when full
        logic read_issue;    // start the RAM read for a read command
        logic read_capture;  // build the read result from RAM data
        logic misc_do;       // clear the table, or idle for an unused command
        logic out_load;      // move the pending result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             hit;
        logic             miss_done;
        logic             out_free;
    } t_dp_stat;

endpackage

// ===== rtl/kstm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Stand-alone; no package dependencies.
`timescale 1ns / 1ps

module kstm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/kstm_ctrl.sv =====
// Controller state machine of the keyed strength merge table.
// Uses kstm_pkg for states and the command/status structs.
`timescale 1ns / 1ps

module kstm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  kstm_pkg::t_dp_stat i_stat,
    output kstm_pkg::t_dp_cmd  o_cmd
);

    kstm_pkg::t_state r_state;
    kstm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kstm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            kstm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = kstm_pkg::ST_MISC;
                end
            end
            kstm_pkg::ST_MISC: begin
                // The captured command is visible here; dispatch on it.
                case (i_stat.cmd)
                    kstm_pkg::CMD_MERGE: n_state = kstm_pkg::ST_SCAN;
                    kstm_pkg::CMD_READ:  n_state = kstm_pkg::ST_READ;
                    default: begin
                        o_cmd.misc_do = 1'b1;
                        n_state       = kstm_pkg::ST_RESULT;
                    end
                endcase
            end
            kstm_pkg::ST_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_stat.hit) begin
                    o_cmd.commit_hit = 1'b1;
                    n_state          = kstm_pkg::ST_RESULT;
                end else if (i_stat.miss_done) begin
                    o_cmd.commit_miss = 1'b1;
                    n_state           = kstm_pkg::ST_RESULT;
                end
            end
            kstm_pkg::ST_READ: begin
                o_cmd.read_issue = 1'b1;
                n_state          = kstm_pkg::ST_READ_DATA;
            end
            kstm_pkg::ST_READ_DATA: begin
                o_cmd.read_capture = 1'b1;
                n_state            = kstm_pkg::ST_RESULT;
            end
            kstm_pkg::ST_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = kstm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = kstm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/kstm_dp.sv =====
// Datapath of the keyed strength merge table: entry RAM, use count, scan pointer,
// strength averaging and result/output registers. Uses kstm_pkg and kstm_ram.
`timescale 1ns / 1ps
`include "keyed_strength_merge_table_defines.svh"

module kstm_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  kstm_pkg::t_dp_cmd                 i_cmd,
    output kstm_pkg::t_dp_stat                o_stat,
    input  logic [kstm_pkg::CMD_W-1:0]        i_command,
    input  logic [kstm_pkg::KEY_W-1:0]        i_mac_key,
    input  logic signed [kstm_pkg::STR_W-1:0] i_strength_in,
    input  logic [kstm_pkg::IDX_W-1:0]        i_read_index,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [kstm_pkg::IDX_W-1:0]        o_slot,
    output logic [kstm_pkg::KEY_W-1:0]        o_mac_out,
    output logic signed [kstm_pkg::STR_W-1:0] o_strength_out,
    output logic                              o_was_new,
    output logic                              o_dropped,
    output logic                              o_slot_valid,
    output logic [kstm_pkg::CNT_W-1:0]        o_used_count
);

    localparam int IDX_W  = kstm_pkg::IDX_W;
    localparam int CNT_W  = kstm_pkg::CNT_W;
    localparam int KEY_W  = kstm_pkg::KEY_W;
    localparam int STR_W  = kstm_pkg::STR_W;
    localparam int WORD_W = kstm_pkg::WORD_W;

    // Captured transaction.
    logic [kstm_pkg::CMD_W-1:0] r_cmd;
    logic [KEY_W-1:0]           r_key;
    logic [STR_W-1:0]           r_str;
    logic [IDX_W-1:0]           r_ridx;

    // Table count and scan pipeline.
    logic [CNT_W-1:0] r_used, n_used;
    logic [CNT_W-1:0] r_addr, n_addr;
    logic             r_pend, n_pend;
    logic [IDX_W-1:0] r_pidx;

    // Pending result.
    logic [IDX_W-1:0] r_res_slot;
    logic [KEY_W-1:0] r_res_key;
    logic [STR_W-1:0] r_res_str;
    logic             r_res_new;
    logic             r_res_drop;
    logic             r_res_valid;
    logic [CNT_W-1:0] r_res_used;

    // Output register.
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_slot;
    logic [KEY_W-1:0] r_out_key;
    logic [STR_W-1:0] r_out_str;
    logic             r_out_new;
    logic             r_out_drop;
    logic             r_out_svalid;
    logic [CNT_W-1:0] r_out_used;

    // RAM ports.
    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    logic [WORD_W-1:0] w_wdata;
    logic              w_re;
    logic [IDX_W-1:0]  w_raddr;
    logic [WORD_W-1:0] w_rdata;
    logic [KEY_W-1:0]  w_rd_key;
    logic [STR_W-1:0]  w_rd_str;

    logic             w_issue;
    logic             w_full;
    logic             w_hit;
    logic             w_miss_done;
    logic             w_read_ok;
    logic [STR_W:0]   w_sum;
    logic [STR_W:0]   w_sum_adj;
    logic [STR_W-1:0] w_avg;

    assign w_rd_key = w_rdata[WORD_W-1:STR_W];
    assign w_rd_str = w_rdata[STR_W-1:0];

    assign w_issue     = i_cmd.scan_en && (r_addr < r_used);
    assign w_full      = (r_used >= CNT_W'(kstm_pkg::ENTRIES));
    assign w_hit       = r_pend && (w_rd_key == r_key);
    assign w_miss_done = !r_pend && (r_addr >= r_used);
    assign w_read_ok   = (CNT_W'(r_ridx) < r_used);

    // Signed average truncated toward zero: add one to a negative sum before halving.
    assign w_sum     = {w_rd_str[STR_W-1], w_rd_str} + {r_str[STR_W-1], r_str};
    assign w_sum_adj = w_sum + {{STR_W{1'b0}}, w_sum[STR_W]};
    assign w_avg     = w_sum_adj[STR_W:1];

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pidx;
        w_wdata = {r_key, w_avg};
        if (i_cmd.commit_hit) begin
            w_we = 1'b1;
        end else if (i_cmd.commit_miss && !w_full) begin
            w_we    = 1'b1;
            w_waddr = r_used[IDX_W-1:0];
            w_wdata = {r_key, r_str};
        end
    end

    assign w_re    = w_issue || i_cmd.read_issue;
    assign w_raddr = i_cmd.read_issue ? r_ridx : r_addr[IDX_W-1:0];

    kstm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (kstm_pkg::ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_used = r_used;
        n_addr = r_addr;
        n_pend = r_pend;
        if (i_cmd.load) begin
            n_addr = '0;
            n_pend = 1'b0;
        end else if (i_cmd.scan_en) begin
            n_pend = w_issue;
            if (w_issue) begin
                n_addr = r_addr + CNT_W'(1);
            end
        end
        if (i_cmd.commit_miss && !w_full) begin
            n_used = r_used + CNT_W'(1);
        end else if (i_cmd.misc_do && (r_cmd == kstm_pkg::CMD_CLEAR)) begin
            n_used = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_used <= n_used;
            r_addr <= n_addr;
            r_pend <= n_pend;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_command;
            r_key  <= i_mac_key;
            r_str  <= $unsigned(i_strength_in);
            r_ridx <= i_read_index;
        end
        if (w_issue) begin
            r_pidx <= r_addr[IDX_W-1:0];
        end

        if (i_cmd.commit_hit) begin
            r_res_slot  <= r_pidx;
            r_res_key   <= r_key;
            r_res_str   <= w_avg;
            r_res_new   <= 1'b0;
            r_res_drop  <= 1'b0;
            r_res_valid <= 1'b1;
            r_res_used  <= r_used;
        end else if (i_cmd.commit_miss) begin
            if (w_full) begin
                r_res_slot  <= '0;
                r_res_key   <= '0;
                r_res_str   <= '0;
                r_res_new   <= 1'b0;
                r_res_drop  <= 1'b1;
                r_res_valid <= 1'b0;
                r_res_used  <= r_used;
            end else begin
                r_res_slot  <= r_used[IDX_W-1:0];
                r_res_key   <= r_key;
                r_res_str   <= r_str;
                r_res_new   <= 1'b1;
                r_res_drop  <= 1'b0;
                r_res_valid <= 1'b1;
                r_res_used  <= r_used + CNT_W'(1);
            end
        end else if (i_cmd.read_capture) begin
            r_res_slot  <= r_ridx;
            r_res_key   <= w_read_ok ? w_rd_key : '0;
            r_res_str   <= w_read_ok ? w_rd_str : '0;
            r_res_new   <= 1'b0;
            r_res_drop  <= 1'b0;
            r_res_valid <= w_read_ok;
            r_res_used  <= r_used;
        end else if (i_cmd.misc_do) begin
            r_res_slot  <= '0;
            r_res_key   <= '0;
            r_res_str   <= '0;
            r_res_new   <= 1'b0;
            r_res_drop  <= 1'b0;
            r_res_valid <= 1'b0;
            r_res_used  <= (r_cmd == kstm_pkg::CMD_CLEAR) ? '0 : r_used;
        end

        if (i_cmd.out_load) begin
            r_out_slot   <= r_res_slot;
            r_out_key    <= r_res_key;
            r_out_str    <= r_res_str;
            r_out_new    <= r_res_new;
            r_out_drop   <= r_res_drop;
            r_out_svalid <= r_res_valid;
            r_out_used   <= r_res_used;
        end
    end

    assign o_stat.cmd       = r_cmd;
    assign o_stat.hit       = w_hit;
    assign o_stat.miss_done = w_miss_done;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_slot         = r_out_slot;
    assign o_mac_out      = r_out_key;
    assign o_strength_out = $signed(r_out_str);
    assign o_was_new      = r_out_new;
    assign o_dropped      = r_out_drop;
    assign o_slot_valid   = r_out_svalid;
    assign o_used_count   = r_out_used;

    `KSTM_ASSERT_NOW(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= CNT_W'(kstm_pkg::ENTRIES))
    `KSTM_ASSERT_NOW(a_hit_xor_miss, i_clk, i_rst_n, i_cmd.scan_en, !(w_hit && w_miss_done))
    `KSTM_ASSERT_NEXT(a_append_counts, i_clk, i_rst_n, i_cmd.commit_miss && !w_full, r_used == $past(r_used) + CNT_W'(1))
    `KSTM_ASSERT_NOW(a_load_when_free, i_clk, i_rst_n, i_cmd.out_load, !r_out_valid || i_out_ready)
    `KSTM_ASSERT_NOW(a_result_flags, i_clk, i_rst_n, o_out_valid && (o_was_new || o_dropped), o_was_new != o_dropped && o_slot_valid == o_was_new)

endmodule

// ===== rtl/keyed_strength_merge_table.sv =====
// Top level of the keyed strength merge table: controller and datapath.
// Uses kstm_pkg, kstm_ctrl and kstm_dp (which holds the kstm_ram entry memory).
`timescale 1ns / 1ps

// The table holds up to 64 records of a 48-bit MAC key and a signed 8-bit
// strength in a single-port-read RAM, so the block works on one transaction at
// a time. A merge scans the used records one per cycle through the RAM read
// port until it finds the key or passes the last used record. A read issues the
// RAM read and then captures the data; a clear or unused command goes straight
// to the result. A finished result waits in the pending result registers while
// the output register still holds a result that has not been taken. The next
// transaction is accepted once the current result has moved into the output
// register, even if that result has not been taken yet. No clearing pass is
// needed after reset.
module keyed_strength_merge_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [kstm_pkg::CMD_W-1:0]        i_command,
    input  logic [kstm_pkg::KEY_W-1:0]        i_mac_key,
    input  logic signed [kstm_pkg::STR_W-1:0] i_strength_in,
    input  logic [kstm_pkg::IDX_W-1:0]        i_read_index,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [kstm_pkg::IDX_W-1:0]        o_slot,
    output logic [kstm_pkg::KEY_W-1:0]        o_mac_out,
    output logic signed [kstm_pkg::STR_W-1:0] o_strength_out,
    output logic                              o_was_new,
    output logic                              o_dropped,
    output logic                              o_slot_valid,
    output logic [kstm_pkg::CNT_W-1:0]        o_used_count
);

    kstm_pkg::t_dp_cmd  w_cmd;
    kstm_pkg::t_dp_stat w_stat;

    kstm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    kstm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_command      (i_command),
        .i_mac_key      (i_mac_key),
        .i_strength_in  (i_strength_in),
        .i_read_index   (i_read_index),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_slot         (o_slot),
        .o_mac_out      (o_mac_out),
        .o_strength_out (o_strength_out),
        .o_was_new      (o_was_new),
        .o_dropped      (o_dropped),
        .o_slot_valid   (o_slot_valid),
        .o_used_count   (o_used_count)
    );

endmodule

// ===== tb/kstm_merge_checker.sv =====
// Checker for the keyed strength merge table: watches both channels, keeps its own
// copy of the table, predicts every result and compares it field by field.
// Depends on kstm_pkg for sizes and command codes.
`timescale 1ns / 1ps

module kstm_merge_checker
    import kstm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [CMD_W-1:0]        i_command,
    input  logic [KEY_W-1:0]        i_mac_key,
    input  logic signed [STR_W-1:0] i_strength_in,
    input  logic [IDX_W-1:0]        i_read_index,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [IDX_W-1:0]        i_slot,
    input  logic [KEY_W-1:0]        i_mac_out,
    input  logic signed [STR_W-1:0] i_strength_out,
    input  logic                    i_was_new,
    input  logic                    i_dropped,
    input  logic                    i_slot_valid,
    input  logic [CNT_W-1:0]        i_used_count,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_appended,
    output int                      o_averaged,
    output int                      o_drops
);

    typedef struct packed {
        logic [IDX_W-1:0]        slot;
        logic [KEY_W-1:0]        mac;
        logic signed [STR_W-1:0] strength;
        logic                    was_new;
        logic                    dropped;
        logic                    slot_valid;
        logic [CNT_W-1:0]        used;
    } t_table_result;

    logic [KEY_W-1:0]        table_keys      [ENTRIES];
    logic signed [STR_W-1:0] table_strengths [ENTRIES];
    int                      table_used = 0;
    t_table_result           pending_records [$];
    int                      fails    = 0;
    int                      appended = 0;
    int                      averaged = 0;
    int                      drops    = 0;

    // Applies one transaction to the local table and returns the result it causes.
    function automatic t_table_result apply_table_op(
        input logic [CMD_W-1:0]        cmd,
        input logic [KEY_W-1:0]        key,
        input logic signed [STR_W-1:0] strength,
        input logic [IDX_W-1:0]        idx
    );
        t_table_result r;
        int            hit;
        int            avg;
        r   = '0;
        hit = -1;
        case (cmd)
            CMD_MERGE: begin
                for (int k = 0; k < ENTRIES; k++) begin
                    if (hit < 0 && k < table_used && table_keys[k] == key) hit = k;
                end
                if (hit >= 0) begin
                    // Integer division of int truncates toward zero.
                    avg = (int'($signed(table_strengths[hit])) + int'($signed(strength))) / 2;
                    table_strengths[hit] = avg[STR_W-1:0];
                    r.slot       = hit[IDX_W-1:0];
                    r.mac        = key;
                    r.strength   = table_strengths[hit];
                    r.slot_valid = 1'b1;
                    averaged++;
                end else if (table_used >= ENTRIES) begin
                    r.dropped = 1'b1;
                    drops++;
                end else begin
                    table_keys[table_used]      = key;
                    table_strengths[table_used] = strength;
                    r.slot       = table_used[IDX_W-1:0];
                    r.mac        = key;
                    r.strength   = strength;
                    r.was_new    = 1'b1;
                    r.slot_valid = 1'b1;
                    table_used++;
                    appended++;
                end
            end
            CMD_READ: begin
                r.slot = idx;
                if (int'(idx) < table_used) begin
                    r.mac        = table_keys[idx];
                    r.strength   = table_strengths[idx];
                    r.slot_valid = 1'b1;
                end
            end
            CMD_CLEAR: begin
                table_used = 0;
            end
            default: begin
            end
        endcase
        r.used = table_used[CNT_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_table_result want;
        if (!i_rst_n) begin
            table_used = 0;
            pending_records.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_records.size() == 0) begin
                    $error("result transaction arrived with no expectation waiting");
                    fails++;
                end else begin
                    want = pending_records.pop_front();
                    check_field("slot", longint'(want.slot), longint'(i_slot));
                    check_field("mac_out", longint'(want.mac), longint'(i_mac_out));
                    check_field("strength_out", longint'($signed(want.strength)),
                                longint'($signed(i_strength_out)));
                    check_field("was_new", longint'(want.was_new), longint'(i_was_new));
                    check_field("dropped", longint'(want.dropped), longint'(i_dropped));
                    check_field("slot_valid", longint'(want.slot_valid),
                                longint'(i_slot_valid));
                    check_field("used_count", longint'(want.used), longint'(i_used_count));
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_records.insert(pending_records.size(),
                    apply_table_op(i_command, i_mac_key, i_strength_in, i_read_index));
            end
        end
        o_pending    <= pending_records.size();
        o_fail_count <= fails;
        o_appended   <= appended;
        o_averaged   <= averaged;
        o_drops      <= drops;
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the keyed strength merge table testbench: clock, reset, stimulus,
// receiver stalls, watchdog and verdict. Uses kstm_pkg, the block and kstm_merge_checker.
`timescale 1ns / 1ps

module tb_top;
    import kstm_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int N_ITEMS     = 1150;
    localparam int QUIET_LIMIT = 5000;
    localparam int LONG_HOLD   = 300;
    localparam int POOL_MAX    = 100;

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_in_valid     = 1'b0;
    logic                    o_in_ready;
    logic [CMD_W-1:0]        i_command      = '0;
    logic [KEY_W-1:0]        i_mac_key      = '0;
    logic signed [STR_W-1:0] i_strength_in  = '0;
    logic [IDX_W-1:0]        i_read_index   = '0;
    logic                    o_out_valid;
    logic                    i_out_ready    = 1'b0;
    logic [IDX_W-1:0]        o_slot;
    logic [KEY_W-1:0]        o_mac_out;
    logic signed [STR_W-1:0] o_strength_out;
    logic                    o_was_new;
    logic                    o_dropped;
    logic                    o_slot_valid;
    logic [CNT_W-1:0]        o_used_count;

    int fail_count;
    int pending;
    int appended;
    int averaged;
    int drops;

    int   n_sent      = 0;
    int   n_reads     = 0;
    int   n_clears    = 0;
    int   burst_left  = 0;
    int   quiet_count = 0;
    logic hold_go     = 1'b0;
    logic hold_done   = 1'b0;

    logic [KEY_W-1:0] key_pool [POOL_MAX];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    keyed_strength_merge_table u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_mac_key      (i_mac_key),
        .i_strength_in  (i_strength_in),
        .i_read_index   (i_read_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_slot         (o_slot),
        .o_mac_out      (o_mac_out),
        .o_strength_out (o_strength_out),
        .o_was_new      (o_was_new),
        .o_dropped      (o_dropped),
        .o_slot_valid   (o_slot_valid),
        .o_used_count   (o_used_count)
    );

    kstm_merge_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_mac_key      (i_mac_key),
        .i_strength_in  (i_strength_in),
        .i_read_index   (i_read_index),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_slot         (o_slot),
        .i_mac_out      (o_mac_out),
        .i_strength_out (o_strength_out),
        .i_was_new      (o_was_new),
        .i_dropped      (o_dropped),
        .i_slot_valid   (o_slot_valid),
        .i_used_count   (o_used_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_appended     (appended),
        .o_averaged     (averaged),
        .o_drops        (drops)
    );

    function automatic logic [KEY_W-1:0] random_key();
        return KEY_W'({$urandom(), $urandom()});
    endfunction

    // Strengths lean on the extremes and on the values around zero.
    function automatic logic signed [STR_W-1:0] pick_strength();
        case ($urandom_range(0, 5))
            0:       return 8'h80;
            1:       return 8'h7F;
            2:       return 8'hFF;
            3:       return 8'h00;
            default: return STR_W'($urandom());
        endcase
    endfunction

    // Offers one transaction, inserting a random gap at the start of each burst.
    task automatic send_item(
        input logic [CMD_W-1:0]        cmd,
        input logic [KEY_W-1:0]        key,
        input logic signed [STR_W-1:0] strength,
        input logic [IDX_W-1:0]        idx
    );
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 30);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_mac_key     <= key;
        i_strength_in <= strength;
        i_read_index  <= idx;
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
        if (cmd == CMD_READ) n_reads++;
        if (cmd == CMD_CLEAR) n_clears++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Receiver: stretches of different stall patterns, plus one long hold-off.
    initial begin
        int mode;
        int stretch;
        stretch = 0;
        mode    = 0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                if (stretch == 0) begin
                    mode    = $urandom_range(0, 3);
                    stretch = $urandom_range(10, 200);
                end
                stretch--;
                case (mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= 1'($urandom_range(0, 1));
                    2:       i_out_ready <= ($urandom_range(0, 9) != 0);
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_count <= 0;
        end else begin
            quiet_count <= quiet_count + 1;
        end
        if (quiet_count >= QUIET_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        int                      seq_count;
        int                      pool_size;
        int                      seq_len;
        int                      pick;
        logic [KEY_W-1:0]        ones;
        seq_count = 0;
        ones      = '1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty read, key and strength extremes, truncation toward zero.
        send_item(CMD_READ, ones, 8'h7F, '0);
        send_item(CMD_MERGE, '0, 8'h80, '1);
        send_item(CMD_MERGE, '0, 8'h80, '0);
        send_item(CMD_MERGE, ones, 8'h7F, '0);
        send_item(CMD_MERGE, ones, 8'h7F, '1);
        send_item(CMD_MERGE, '0, 8'h7F, '0);
        send_item(CMD_MERGE, '0, 8'hFD, '0);
        send_item(CMD_MERGE, {24{2'b01}}, 8'hFF, '0);
        send_item(CMD_MERGE, {24{2'b10}}, 8'h00, '0);
        send_item(CMD_MERGE, {24{2'b10}}, 8'hFF, '0);
        send_item(CMD_READ, '0, '0, 6'd0);
        send_item(CMD_READ, '0, '0, 6'd3);
        send_item(CMD_READ, '0, '0, 6'd4);
        send_item(CMD_READ, ones, 8'hFF, '1);
        send_item(CMD_UNUSED, ones, 8'h80, '1);
        send_item(CMD_CLEAR, ones, 8'h7F, '1);
        send_item(CMD_READ, '0, '0, 6'd0);
        send_item(CMD_MERGE, ones, 8'h80, '0);
        drain_results();

        // Random: mostly a clear followed by merges from a key pool that may
        // overflow the table, with reads, stray keys and noise mixed in.
        while (n_sent < N_ITEMS) begin
            seq_count++;
            pool_size = $urandom_range(1, POOL_MAX);
            for (int p = 0; p < pool_size; p++) begin
                // Some keys differ from the previous one in a single bit.
                if (p > 0 && $urandom_range(0, 3) == 0) begin
                    key_pool[p] = key_pool[p-1] ^ (48'd1 << $urandom_range(0, KEY_W - 1));
                end else begin
                    key_pool[p] = random_key();
                end
            end
            if ($urandom_range(0, 7) != 0) begin
                send_item(CMD_CLEAR, random_key(), STR_W'($urandom()), IDX_W'($urandom()));
            end
            seq_len = $urandom_range(20, 150);
            for (int j = 0; j < seq_len && n_sent < N_ITEMS; j++) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    send_item(CMD_MERGE, key_pool[$urandom_range(0, pool_size - 1)],
                              pick_strength(), IDX_W'($urandom()));
                end else if (pick < 86) begin
                    send_item(CMD_READ, random_key(), STR_W'($urandom()),
                              IDX_W'($urandom()));
                end else if (pick < 92) begin
                    send_item(CMD_MERGE, random_key(), pick_strength(), IDX_W'($urandom()));
                end else if (pick < 97) begin
                    send_item(CMD_UNUSED, random_key(), STR_W'($urandom()),
                              IDX_W'($urandom()));
                end else begin
                    send_item(CMD_CLEAR, random_key(), STR_W'($urandom()),
                              IDX_W'($urandom()));
                end
                if (!hold_go && n_sent >= 400) hold_go <= 1'b1;
            end
            if (seq_count == 2 || $urandom_range(0, 3) == 0) drain_results();
        end

        drain_results();
        repeat (100) @(posedge i_clk);

        $display("Sent %0d transactions in %0d random sequences: %0d reads, %0d clears.",
                 n_sent, seq_count, n_reads, n_clears);
        $display("Merges appended %0d, averaged %0d and dropped %0d; long receiver hold-off %0s.",
                 appended, averaged, drops, hold_done ? "done" : "not done");
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
